### src/cpe_pkg.sv
// Shared types and constants for the constrained permutation enumerator.
// Holds the request/result beat structs and the controller/datapath interface.
// No dependencies.
package cpe_pkg;

   localparam int ITEM_W  = 4;
   localparam int COUNT_W = 5;
   localparam int MASK_W  = 16;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

   // Request actions
   typedef enum logic [1:0] {
      ACT_ADD     = 2'd0,
      ACT_CLEAR   = 2'd1,
      ACT_RESTART = 2'd2,
      ACT_NEXT    = 2'd3
   } action_type;

   typedef struct packed {
      action_type          action;
      logic [ITEM_W-1:0]   before_item;
      logic [ITEM_W-1:0]   after_item;
   } req_type;

   typedef struct packed {
      logic [ITEM_W-1:0]   position;
      logic [ITEM_W-1:0]   item_value;
      logic                last;
      logic                done_res;
   } rsp_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ADD,
      OP_CLEAR,
      OP_RESTART,
      OP_CAND_ZERO,
      OP_POP,
      OP_CAND_NEXT,
      OP_CLOS_INIT,
      OP_CLOS_STEP,
      OP_PLACE,
      OP_EXHAUST,
      OP_EMIT,
      OP_DONE
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic exhausted;
      logic at_full;
      logic level_zero;
      logic cand_out;
      logic cand_ok;
      logic clos_stable;
      logic clos_complete;
      logic place_last;
      logic emit_last;
   } stat_type;

endpackage

### src/cpe_dpath.sv
// Datapath of the permutation enumerator: precedence table, placement stack,
// used set, reachability closure and result beat register. Uses cpe_pkg.
module cpe_dpath import cpe_pkg::*; #(
   parameter int MAX_ITEMS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  req_type            req_data,
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_data,
   output stat_type           stat,
   output logic               rsp_valid,
   output rsp_type            rsp_data
);

   localparam int CAP   = (MAX_ITEMS < 16) ? MAX_ITEMS : 16;
   localparam int IDX_W = $clog2(CAP);
   localparam logic [COUNT_W-1:0] CAP_N = COUNT_W'(CAP);
   localparam logic [CAP-1:0] ONE_HOT0 = {{(CAP-1){1'b0}}, 1'b1};

   logic [MASK_W-1:0]  mask_ff   [CAP];
   logic [ITEM_W-1:0]  placed_ff [CAP];
   logic [CAP-1:0]     used_ff;
   logic [CAP-1:0]     set_ff;
   logic [CAP-1:0]     set_in;
   logic [COUNT_W-1:0] level_ff;
   logic [COUNT_W-1:0] cand_ff;
   logic [ITEM_W-1:0]  k_ff;
   logic               exh_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic [COUNT_W-1:0] item_n;
   logic [CAP-1:0]     full;
   logic [CAP-1:0]     ready_used;
   logic [CAP-1:0]     grow;
   logic [MASK_W-1:0]  used16;
   logic [MASK_W-1:0]  set16;
   logic [IDX_W-1:0]   cand_idx;
   logic [CAP-1:0]     cand_bit;
   logic [COUNT_W-1:0] level_dec;
   logic [IDX_W-1:0]   rd_idx;
   logic [ITEM_W-1:0]  rd_val;
   logic [CAP-1:0]     pop_bit;
   logic [COUNT_W-1:0] pop_cand;
   logic               restart;

   // Effective item count, saturated to 1..CAP
   always_comb begin
      if (count_ff == '0) begin
         item_n = COUNT_W'(1);
      end else if (count_ff > CAP_N) begin
         item_n = CAP_N;
      end else begin
         item_n = count_ff;
      end
   end

   assign used16 = MASK_W'(used_ff);
   assign set16  = MASK_W'(set_ff);

   // Per item: in range, predecessors covered by the used set and by the closure set
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         full[i]       = COUNT_W'(i) < item_n;
         ready_used[i] = (mask_ff[i] & ~used16) == '0;
         grow[i]       = full[i] && !set_ff[i] && ((mask_ff[i] & ~set16) == '0);
      end
   end

   // One closure pass: add every item whose predecessors are all in the set
   assign set_in = set_ff | grow;

   assign cand_idx = cand_ff[IDX_W-1:0];
   assign cand_bit = ONE_HOT0 << cand_idx;

   // Stack read: top entry on pop, emit index otherwise
   assign level_dec = level_ff - COUNT_W'(1);
   assign rd_idx    = (cmd.op == OP_POP) ? level_dec[IDX_W-1:0] : k_ff[IDX_W-1:0];
   assign rd_val    = placed_ff[rd_idx];
   assign pop_bit   = ONE_HOT0 << rd_val[IDX_W-1:0];
   assign pop_cand  = {1'b0, rd_val} + COUNT_W'(1);

   assign stat.exhausted     = exh_ff;
   assign stat.at_full       = level_ff == item_n;
   assign stat.level_zero    = level_ff == '0;
   assign stat.cand_out      = cand_ff >= item_n;
   assign stat.cand_ok       = !used_ff[cand_idx] && ready_used[cand_idx];
   assign stat.clos_stable   = set_in == set_ff;
   assign stat.clos_complete = (set_ff & full) == full;
   assign stat.place_last    = (level_ff + COUNT_W'(1)) == item_n;
   assign stat.emit_last     = ({1'b0, k_ff} + COUNT_W'(1)) == item_n;

   assign restart = csr_we || cmd.op == OP_ADD || cmd.op == OP_CLEAR
                 || cmd.op == OP_RESTART;

   // Control state: table, used set, level, exhausted flag, count, strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAP; i++) begin
            mask_ff[i] <= '0;
         end
         used_ff      <= '0;
         level_ff     <= '0;
         exh_ff       <= 1'b0;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            count_ff <= csr_data;
         end
         case (cmd.op)
            OP_ADD: begin
               if ({1'b0, req_data.after_item} < CAP_N) begin
                  mask_ff[req_data.after_item[IDX_W-1:0]] <=
                     mask_ff[req_data.after_item[IDX_W-1:0]]
                     | (MASK_W'(1) << req_data.before_item);
               end
            end
            OP_CLEAR: begin
               for (int i = 0; i < CAP; i++) begin
                  mask_ff[i] <= '0;
               end
            end
            OP_POP: begin
               level_ff <= level_dec;
               used_ff  <= used_ff & ~pop_bit;
            end
            OP_PLACE: begin
               level_ff <= level_ff + COUNT_W'(1);
               used_ff  <= used_ff | cand_bit;
            end
            OP_EXHAUST: begin
               exh_ff <= 1'b1;
            end
            OP_EMIT, OP_DONE: begin
               rsp_valid_ff <= 1'b1;
            end
            default: begin
            end
         endcase
         if (restart) begin
            used_ff  <= '0;
            level_ff <= '0;
            exh_ff   <= 1'b0;
         end
      end
   end

   // Payload: stack entries, candidate, closure set, emit index, result beat
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAND_ZERO: begin
            cand_ff <= '0;
         end
         OP_POP: begin
            cand_ff <= pop_cand;
         end
         OP_CAND_NEXT: begin
            cand_ff <= cand_ff + COUNT_W'(1);
         end
         OP_CLOS_INIT: begin
            set_ff <= used_ff | cand_bit;
         end
         OP_CLOS_STEP: begin
            set_ff <= set_in;
         end
         OP_PLACE: begin
            placed_ff[level_ff[IDX_W-1:0]] <= cand_ff[ITEM_W-1:0];
            cand_ff <= '0;
            k_ff    <= '0;
         end
         OP_EMIT: begin
            rsp_data_ff.position   <= k_ff;
            rsp_data_ff.item_value <= rd_val;
            rsp_data_ff.last       <= stat.emit_last;
            rsp_data_ff.done_res   <= 1'b0;
            k_ff <= k_ff + ITEM_W'(1);
         end
         OP_DONE: begin
            rsp_data_ff.position   <= '0;
            rsp_data_ff.item_value <= '0;
            rsp_data_ff.last       <= 1'b1;
            rsp_data_ff.done_res   <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A done beat is always a final beat at position zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.last && rsp_data.position == '0)
      else $error("done beat malformed");

   // Stack depth never exceeds the item count
   assert property (@(posedge clock) disable iff (reset) level_ff <= item_n)
      else $error("stack level above item count");

   // Used set tracks the stack exactly
   assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(level_ff))
      else $error("used set out of step with stack level");

endmodule

### src/cpe_ctrl.sv
// Controller state machine of the permutation enumerator: decodes requests and
// steps the search, closure and result beats. Uses cpe_pkg.
module cpe_ctrl import cpe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  action_type action,
   input  stat_type   stat,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CLOS,
      S_EMIT,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy   = state_ff != S_IDLE;
   assign accept = start && !busy;

   // Next state and datapath operation
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (action)
                  ACT_ADD:     cmd.op = OP_ADD;
                  ACT_CLEAR:   cmd.op = OP_CLEAR;
                  ACT_RESTART: cmd.op = OP_RESTART;
                  ACT_NEXT: begin
                     if (stat.exhausted) begin
                        state_in = S_DONE;
                     end else begin
                        cmd.op   = stat.at_full ? OP_POP : OP_CAND_ZERO;
                        state_in = S_SCAN;
                     end
                  end
                  default: cmd.op = OP_NONE;
               endcase
            end
         end
         // Try one candidate per cycle until one passes to the closure, backtrack when none is left
         S_SCAN: begin
            if (stat.cand_out) begin
               if (stat.level_zero) begin
                  cmd.op   = OP_EXHAUST;
                  state_in = S_DONE;
               end else begin
                  cmd.op = OP_POP;
               end
            end else if (stat.cand_ok) begin
               cmd.op   = OP_CLOS_INIT;
               state_in = S_CLOS;
            end else begin
               cmd.op = OP_CAND_NEXT;
            end
         end
         // Grow the closure until stable, then place or reject the candidate
         S_CLOS: begin
            if (!stat.clos_stable) begin
               cmd.op = OP_CLOS_STEP;
            end else if (stat.clos_complete) begin
               cmd.op   = OP_PLACE;
               state_in = stat.place_last ? S_EMIT : S_SCAN;
            end else begin
               cmd.op   = OP_CAND_NEXT;
               state_in = S_SCAN;
            end
         end
         S_EMIT: begin
            cmd.op = OP_EMIT;
            if (stat.emit_last) begin
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            cmd.op   = OP_DONE;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Only a next request makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start) && $past(action) == ACT_NEXT)
      else $error("busy without a next request");

   // No candidate scan once the list is used up
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> !stat.exhausted)
      else $error("scan while exhausted");

endmodule

### src/constrained_permutation_enumerator.sv
// Top level of the constrained permutation enumerator: joins controller and
// datapath. Uses cpe_pkg, cpe_ctrl and cpe_dpath.
// Setup actions (add, clear, restart) and register writes take effect in the accept cycle.
// A next request scans one candidate per cycle; each accepted candidate grows a
// closure until it is stable; backtracking pops one level per cycle.
// Results follow as one beat per item of the saturated count, one per cycle, or one done beat.
// Reset is synchronous; it clears the table and stack and sets the count to 16. Results cannot be held off.
module constrained_permutation_enumerator import cpe_pkg::*; #(
   parameter int MAX_ITEMS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   // Take register writes only when no request is in flight or being offered
   assign csr_ready = !busy && !start;

   cpe_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_data.action),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   cpe_dpath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
